### rtl/pvalu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed SIMD vector ALU package
// Shared types, operation codes and lane width codes for the packed SIMD ALU.
// ----------------------------------------------------------------------------
package pvalu_pkg;

   // Operation codes of a request.
   localparam logic [1:0] OP_ADD_SCALAR = 2'd0;
   localparam logic [1:0] OP_MUL_SCALAR = 2'd1;
   localparam logic [1:0] OP_ADD_VECTOR = 2'd2;
   localparam logic [1:0] OP_SUM_LANES  = 2'd3;

   // Lane width codes; the unused fourth code behaves as 32-bit lanes.
   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_32 = 2'd2;

   // The 128-bit register is handled as four 32-bit slices, one per lane unit.
   localparam int unsigned NUM_SLICES = 4;
   localparam int unsigned SLICE_BITS = 32;
   localparam int unsigned VEC_BITS   = NUM_SLICES * SLICE_BITS;

   typedef enum logic [1:0] {
      SIZE_8,
      SIZE_16,
      SIZE_32
   } lane_size_type;

   // Per-request control shared by all lane units.
   typedef struct packed {
      logic [1:0]    op;
      lane_size_type size;
      logic [31:0]   scalar;
   } lane_ctrl_type;

   // Which sub-lanes of a slice lie wholly inside the active register bytes.
   typedef struct packed {
      logic [3:0] en8;
      logic [1:0] en16;
      logic       en32;
   } lane_en_type;

   // Data handed from the lane stage to the merging stage.
   typedef struct packed {
      logic [VEC_BITS-1:0]                    vec;
      logic [NUM_SLICES-1:0][SLICE_BITS-1:0]  partial;
      logic                                   is_sum;
      logic                                   mismatch;
   } stage_data_type;

   function automatic lane_size_type map_width(input logic [1:0] code);
      lane_size_type size;
      case (code)
         WIDTH_8:  size = SIZE_8;
         WIDTH_16: size = SIZE_16;
         default:  size = SIZE_32;
      endcase
      return size;
   endfunction

endpackage

### rtl/pvalu_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed SIMD ALU lane unit
// Works on one 32-bit slice of the register as four 8-bit, two 16-bit or one
// 32-bit lane, and forms the sign-extended sum of its active lanes.
// ----------------------------------------------------------------------------
module pvalu_lane (
   input  pvalu_pkg::lane_ctrl_type ctrl,
   input  pvalu_pkg::lane_en_type   en,
   input  logic [31:0]              cur,
   input  logic [31:0]              other,
   output logic [31:0]              result,
   output logic [31:0]              partial
);
   import pvalu_pkg::*;

   logic [31:0] res8, res16, res32;
   logic [31:0] part8, part16, part32;

   always_comb begin
      logic [7:0]  val8;
      logic [15:0] val16;
      logic [31:0] val32;
      res8  = cur;
      res16 = cur;
      res32 = cur;
      part8  = '0;
      part16 = '0;
      part32 = '0;

      for (int j = 0; j < 4; j++) begin
         if (ctrl.op == OP_MUL_SCALAR) val8 = cur[8*j +: 8] * ctrl.scalar[7:0];
         else if (ctrl.op == OP_ADD_VECTOR) val8 = cur[8*j +: 8] + other[8*j +: 8];
         else val8 = cur[8*j +: 8] + ctrl.scalar[7:0];
         if (en.en8[j]) begin
            res8[8*j +: 8] = val8;
            part8 = part8 + {{24{cur[8*j+7]}}, cur[8*j +: 8]};
         end
      end

      for (int j = 0; j < 2; j++) begin
         if (ctrl.op == OP_MUL_SCALAR) val16 = cur[16*j +: 16] * ctrl.scalar[15:0];
         else if (ctrl.op == OP_ADD_VECTOR) val16 = cur[16*j +: 16] + other[16*j +: 16];
         else val16 = cur[16*j +: 16] + ctrl.scalar[15:0];
         if (en.en16[j]) begin
            res16[16*j +: 16] = val16;
            part16 = part16 + {{16{cur[16*j+15]}}, cur[16*j +: 16]};
         end
      end

      if (ctrl.op == OP_MUL_SCALAR) val32 = cur * ctrl.scalar;
      else if (ctrl.op == OP_ADD_VECTOR) val32 = cur + other;
      else val32 = cur + ctrl.scalar;
      if (en.en32) begin
         res32  = val32;
         part32 = cur;
      end
   end

   always_comb begin
      case (ctrl.size)
         SIZE_8: begin
            result  = res8;
            partial = part8;
         end
         SIZE_16: begin
            result  = res16;
            partial = part16;
         end
         default: begin
            result  = res32;
            partial = part32;
         end
      endcase
   end

endmodule

### rtl/pvalu_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed SIMD ALU merging stage
// Adds the slice sums into the 32-bit total and holds the response register.
// ----------------------------------------------------------------------------
module pvalu_merge (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  pvalu_pkg::stage_data_type in_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [63:0]               rsp_vec_low,
   output logic [63:0]               rsp_vec_high,
   output logic signed [31:0]        rsp_total,
   output logic                      rsp_mismatch
);
   import pvalu_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] vec_low_ff, vec_high_ff;
   logic [31:0] total_ff, total_in;
   logic        mismatch_ff;
   logic        load;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      total_in = '0;
      if (in_data.is_sum) begin
         for (int k = 0; k < NUM_SLICES; k++) begin
            total_in = total_in + in_data.partial[k];
         end
      end
   end

   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         vec_low_ff  <= in_data.vec[63:0];
         vec_high_ff <= in_data.vec[127:64];
         total_ff    <= total_in;
         mismatch_ff <= in_data.mismatch;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_vec_low  = vec_low_ff;
   assign rsp_vec_high = vec_high_ff;
   assign rsp_total    = $signed(total_ff);
   assign rsp_mismatch = mismatch_ff;

`ifndef SYNTHESIS
   // A request that is not a lane sum reports a zero total.
   assert property (@(posedge clock) disable iff (reset)
      (load && !in_data.is_sum) |=> (rsp_total == '0))
      else $error("nonzero total for a request other than a lane sum");

   // A mismatch can only come with an unchanged total of zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_mismatch) |-> (rsp_total == '0))
      else $error("mismatch flag raised on a lane sum");
`endif

endmodule

### rtl/packed_simd_vector_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed SIMD vector ALU
// A 128-bit accumulator register split into 8-, 16- or 32-bit signed lanes,
// with scalar add, scalar multiply, vector add and lane sum operations.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Contents
//   req_*     in         req_valid / req_ready  op, scalar, vector operand, tag
//   rsp_*     out        rsp_valid / rsp_ready  register, total, mismatch flag
//   csr_*     in         csr_wr_en              lane width, no wait, no read
//
// One request is accepted per cycle while the lane stage can take it. The
// accumulator register is updated in the cycle of acceptance by four 32-bit
// lane units working in parallel, so a following request sees the new
// contents at once. The lane stage output register holds the new contents
// and lane sums; the merging stage then adds the lane sums and registers the
// response, which it offers until it is taken.
// Reset (synchronous) clears the register, the lane width and both stages.
// A stalled response holds its stage; the lane stage keeps accepting until
// both stages are full.
// ----------------------------------------------------------------------------
module packed_simd_vector_alu #(
   parameter int REG_BYTES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_scalar,
   input  logic [63:0]        req_other_low,
   input  logic [63:0]        req_other_high,
   input  logic [1:0]         req_other_width,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [63:0]        rsp_vec_low,
   output logic [63:0]        rsp_vec_high,
   output logic signed [31:0] rsp_total,
   output logic               rsp_mismatch,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_wr_data
);
   import pvalu_pkg::*;

   // Only the first sixteen register bytes at most carry lanes; a lane must
   // fit wholly inside the active bytes to take part.
   localparam int ACTIVE_BYTES = (REG_BYTES > 16) ? 16 : REG_BYTES;
   localparam int ACTIVE_BITS  = ACTIVE_BYTES * 8;

   // Configured lane width.
   logic [1:0] lane_width_ff;

   // Accumulator register.
   logic [VEC_BITS-1:0] vec_ff, vec_in;

   // Lane stage output register.
   logic           s1_valid_ff, s1_valid_in;
   stage_data_type s1_data_ff, s1_data_in;
   logic           s1_ready;

   logic                                   accept;
   logic                                   mismatch;
   logic                                   write_vec;
   lane_ctrl_type                          ctrl;
   logic [VEC_BITS-1:0]                    other;
   logic [VEC_BITS-1:0]                    lane_result;
   logic [NUM_SLICES-1:0][SLICE_BITS-1:0]  lane_partial;

   assign other = {req_other_high, req_other_low};

   assign ctrl.op     = req_op;
   assign ctrl.size   = map_width(lane_width_ff);
   assign ctrl.scalar = $unsigned(req_scalar);

   // A vector add only goes ahead when the operand's lane width agrees.
   assign mismatch  = (req_op == OP_ADD_VECTOR) &&
                      (map_width(req_other_width) != ctrl.size);
   assign write_vec = (req_op != OP_SUM_LANES) && !mismatch;

   genvar k;
   generate
      for (k = 0; k < NUM_SLICES; k++) begin : g_lane
         lane_en_type en;

         for (genvar j = 0; j < 4; j++) begin : g_en8
            assign en.en8[j] = ((k * 32 + j * 8 + 8) <= ACTIVE_BITS);
         end
         for (genvar j = 0; j < 2; j++) begin : g_en16
            assign en.en16[j] = ((k * 32 + j * 16 + 16) <= ACTIVE_BITS);
         end
         assign en.en32 = ((k * 32 + 32) <= ACTIVE_BITS);

         pvalu_lane u_lane (
            .ctrl    (ctrl),
            .en      (en),
            .cur     (vec_ff[k*SLICE_BITS +: SLICE_BITS]),
            .other   (other[k*SLICE_BITS +: SLICE_BITS]),
            .result  (lane_result[k*SLICE_BITS +: SLICE_BITS]),
            .partial (lane_partial[k])
         );
      end
   endgenerate

   assign req_ready = !s1_valid_ff || s1_ready;
   assign accept    = req_valid && req_ready;

   assign vec_in = (accept && write_vec) ? lane_result : vec_ff;

   assign s1_data_in.vec      = vec_in;
   assign s1_data_in.partial  = lane_partial;
   assign s1_data_in.is_sum   = (req_op == OP_SUM_LANES);
   assign s1_data_in.mismatch = mismatch;

   assign s1_valid_in = accept || (s1_valid_ff && !s1_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_width_ff <= WIDTH_8;
         vec_ff        <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            lane_width_ff <= csr_wr_data;
         end
         vec_ff      <= vec_in;
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_data_ff <= s1_data_in;
      end
   end

   pvalu_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s1_valid_ff),
      .in_ready     (s1_ready),
      .in_data      (s1_data_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_vec_low  (rsp_vec_low),
      .rsp_vec_high (rsp_vec_high),
      .rsp_total    (rsp_total),
      .rsp_mismatch (rsp_mismatch)
   );

`ifndef SYNTHESIS
   // A lane sum never changes the accumulator.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_SUM_LANES) |=> $stable(vec_ff))
      else $error("accumulator changed by a lane sum");

   // A width mismatch leaves the accumulator as it was and reports it so.
   assert property (@(posedge clock) disable iff (reset)
      (accept && mismatch) |=> (s1_data_ff.vec == $past(vec_ff) && $stable(vec_ff)))
      else $error("accumulator changed by a mismatched vector add");

   // The lane stage holds its request while the merging stage is full.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_ready) |=> (s1_valid_ff && $stable(s1_data_ff)))
      else $error("lane stage lost a stalled request");

   // The response always shows the accumulator as left by its request.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (s1_data_ff.vec == vec_ff))
      else $error("lane stage and accumulator disagree");
`endif

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packed SIMD vector ALU testbench
// Sends requests to the ALU under several lane width settings; both channels
// stall at random except in the last two phases. A local model of the
// accumulator predicts each response, checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;
   import pvalu_pkg::*;

   // A run needs far fewer cycles than this, even with heavy stalls.
   localparam int unsigned CYCLE_LIMIT     = 200000;
   localparam int unsigned RANDOM_PER_PHASE = 250;
   // Cycles allowed for the response pipeline to settle before a CSR write
   // and at the end of the run.
   localparam int unsigned SETTLE_CYCLES   = 6;

   typedef struct {
      logic [1:0]         op;
      logic signed [31:0] scalar;
      logic [63:0]        other_low;
      logic [63:0]        other_high;
      logic [1:0]         other_width;
   } alu_request_type;

   typedef struct {
      logic [63:0] vec_low;
      logic [63:0] vec_high;
      logic [31:0] total;
      logic        mismatch;
   } alu_result_type;

   // All inputs carry known values from time zero.
   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic [1:0]         req_op          = OP_ADD_SCALAR;
   logic signed [31:0] req_scalar      = '0;
   logic [63:0]        req_other_low   = '0;
   logic [63:0]        req_other_high  = '0;
   logic [1:0]         req_other_width = WIDTH_8;
   logic               rsp_ready       = 1'b0;
   logic               csr_wr_en       = 1'b0;
   logic [1:0]         csr_wr_data     = WIDTH_8;
   logic               req_ready;
   logic               rsp_valid;
   logic [63:0]        rsp_vec_low;
   logic [63:0]        rsp_vec_high;
   logic signed [31:0] rsp_total;
   logic               rsp_mismatch;

   // Requests waiting to be driven, and responses predicted but not yet seen.
   alu_request_type pending_requests[$];
   alu_result_type  expected_results[$];

   // Model state: the accumulator and the lane width the block was given.
   logic [127:0] model_acc = '0;
   logic [1:0]   model_lane_width = WIDTH_8;

   // Stall rates in percent, changed from phase to phase.
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned error_count   = 0;
   int unsigned cycle_count   = 0;

   packed_simd_vector_alu i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_scalar      (req_scalar),
      .req_other_low   (req_other_low),
      .req_other_high  (req_other_high),
      .req_other_width (req_other_width),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_vec_low     (rsp_vec_low),
      .rsp_vec_high    (rsp_vec_high),
      .rsp_total       (rsp_total),
      .rsp_mismatch    (rsp_mismatch),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #1 clock = ~clock;

   // The fourth width code has no lane size of its own and behaves as 32 bits.
   function automatic int unsigned lane_bits_of(input logic [1:0] code);
      case (code)
         WIDTH_8:  return 8;
         WIDTH_16: return 16;
         default:  return 32;
      endcase
   endfunction

   // Applies one request to the accumulator and returns the response it
   // causes; the new accumulator contents are the vec fields of the response.
   function automatic alu_result_type compute_alu_result(input logic [127:0] acc,
         input logic [1:0] width_code, input alu_request_type rq);
      alu_result_type res;
      int unsigned    bits;
      int unsigned    shift;
      logic [31:0]    mask;
      logic [31:0]    lane;
      logic [127:0]   other;
      bits  = lane_bits_of(width_code);
      mask  = (bits == 32) ? 32'hFFFF_FFFF : (32'd1 << bits) - 32'd1;
      other = {rq.other_high, rq.other_low};
      res.total    = '0;
      res.mismatch = 1'b0;
      // A vector add whose tag names another lane size leaves the register
      // alone; tags are compared after the fourth code is folded into 32 bits.
      if (rq.op == OP_ADD_VECTOR && lane_bits_of(rq.other_width) != bits) begin
         res.mismatch = 1'b1;
      end else begin
         for (int unsigned lane_idx = 0; lane_idx < 128 / bits; lane_idx++) begin
            shift = lane_idx * bits;
            lane  = 32'(acc >> shift) & mask;
            case (rq.op)
               OP_ADD_SCALAR: lane = lane + rq.scalar;
               OP_MUL_SCALAR: lane = lane * rq.scalar;
               OP_ADD_VECTOR: lane = lane + (32'(other >> shift) & mask);
               default: begin
                  // Lanes are signed: sign-extend before the 32-bit sum.
                  if (bits < 32 && lane[bits-1])
                     lane = lane | ~mask;
                  res.total = res.total + lane;
               end
            endcase
            if (rq.op != OP_SUM_LANES)
               acc = (acc & ~({96'd0, mask} << shift)) | ({96'd0, lane & mask} << shift);
         end
      end
      res.vec_low  = acc[63:0];
      res.vec_high = acc[127:64];
      return res;
   endfunction

   task automatic queue_request(input logic [1:0] op, input logic [31:0] scalar,
         input logic [63:0] other_low, input logic [63:0] other_high,
         input logic [1:0] other_width);
      alu_request_type rq;
      rq.op          = op;
      rq.scalar      = scalar;
      rq.other_low   = other_low;
      rq.other_high  = other_high;
      rq.other_width = other_width;
      pending_requests.push_back(rq);
   endtask

   // Random request. Scalars lean toward the corners of the signed range and
   // toward small values so that lanes do not all collapse to zero after a
   // few multiplies. Most vector adds carry a matching tag so that they get
   // past the width check.
   task automatic queue_random_request(input logic [1:0] width_code);
      logic [31:0] scalar;
      logic [63:0] other_low;
      logic [63:0] other_high;
      logic [1:0]  tag;
      case ($urandom_range(9))
         0:       scalar = 32'h8000_0000;
         1:       scalar = 32'h7FFF_FFFF;
         2:       scalar = 32'hFFFF_FFFF;
         3, 4:    scalar = 32'($signed($urandom_range(8)) - 4);
         default: scalar = $urandom;
      endcase
      other_low  = {$urandom, $urandom};
      other_high = {$urandom, $urandom};
      if ($urandom_range(19) == 0) begin
         other_low  = '1;
         other_high = '1;
      end
      if ($urandom_range(9) < 7) begin
         tag = width_code;
         // Codes two and three name the same lane size, so both must pass.
         if (lane_bits_of(width_code) == 32)
            tag = $urandom_range(1) ? WIDTH_32 : 2'd3;
      end else begin
         tag = 2'($urandom_range(3));
      end
      queue_request(2'($urandom_range(3)), scalar, other_low, other_high, tag);
   endtask

   task automatic wait_until_drained;
      while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string field, input logic [63:0] expected,
         input logic [63:0] actual);
      if (expected !== actual) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, expected,
                  actual);
      end
   endtask

   // Driver. A request stays on the port until it is taken; a new one is
   // loaded in the same edge as the handshake so that back-to-back requests
   // keep req_valid high without a gap. The model is advanced on acceptance,
   // because the block updates its register in that very cycle.
   always @(posedge clock) begin
      alu_request_type rq;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            rq.op          = req_op;
            rq.scalar      = req_scalar;
            rq.other_low   = req_other_low;
            rq.other_high  = req_other_high;
            rq.other_width = req_other_width;
            expected_results.push_back(compute_alu_result(model_acc, model_lane_width, rq));
            model_acc = {expected_results[$].vec_high, expected_results[$].vec_low};
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               rq = pending_requests.pop_front();
               req_op          <= rq.op;
               req_scalar      <= rq.scalar;
               req_other_low   <= rq.other_low;
               req_other_high  <= rq.other_high;
               req_other_width <= rq.other_width;
               req_valid       <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor. Responses are taken in order and matched against the oldest
   // prediction; rsp_ready is redrawn every cycle to stall the output.
   always @(posedge clock) begin
      alu_result_type exp_rsp;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response, expected none, actual %h %h %h %b",
                        $time, rsp_vec_high, rsp_vec_low, rsp_total, rsp_mismatch);
            end else begin
               exp_rsp = expected_results.pop_front();
               check_field("vec_low", exp_rsp.vec_low, rsp_vec_low);
               check_field("vec_high", exp_rsp.vec_high, rsp_vec_high);
               check_field("total", {32'd0, exp_rsp.total}, {32'd0, rsp_total});
               check_field("mismatch", {63'd0, exp_rsp.mismatch}, {63'd0, rsp_mismatch});
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[packed_simd_vector_alu] ERROR");
         $finish;
      end
   end

   // Stimulus. Each phase sets a lane width while the block is idle, then
   // queues its requests. The widths visit every code, the unused fourth one
   // included. The stall pattern goes through three settings in order over
   // the run: light input and heavy output stalls first, then the reverse,
   // then no stalls at all.
   initial begin
      logic [1:0] phase_width[8];
      phase_width = '{WIDTH_8, 2'd3, WIDTH_16, WIDTH_32, WIDTH_8, 2'd3, WIDTH_32,
                      WIDTH_16};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (phase_width[phase]) begin
         wait_until_drained();
         @(posedge clock);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= phase_width[phase];
         model_lane_width = phase_width[phase];
         @(posedge clock);
         csr_wr_en <= 1'b0;
         case (phase * 3 / 8)
            0: begin
               send_idle_pct = 23;
               recv_idle_pct = 70;
            end
            1: begin
               send_idle_pct = 70;
               recv_idle_pct = 23;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (phase == 0) begin
            // 8-bit lanes from a cleared register: sum of zero, then drive
            // every lane to its positive limit, wrap it past the top, and
            // multiply the negative limit by minus one, which wraps onto
            // itself.
            queue_request(OP_SUM_LANES, 32'd0, '0, '0, WIDTH_8);
            queue_request(OP_ADD_SCALAR, 32'd127, '0, '0, WIDTH_8);
            queue_request(OP_SUM_LANES, 32'd0, '0, '0, WIDTH_8);
            queue_request(OP_ADD_SCALAR, 32'd1, '0, '0, WIDTH_8);
            queue_request(OP_SUM_LANES, 32'd0, '0, '0, WIDTH_8);
            queue_request(OP_MUL_SCALAR, 32'hFFFF_FFFF, '0, '0, WIDTH_8);
            // An all-ones vector subtracts one from each lane. Tags for the
            // other sizes, and the fourth code, must each be refused.
            queue_request(OP_ADD_VECTOR, 32'd0, '1, '1, WIDTH_8);
            queue_request(OP_ADD_VECTOR, 32'd5, '1, '1, WIDTH_16);
            queue_request(OP_ADD_VECTOR, 32'd5, '1, '1, WIDTH_32);
            queue_request(OP_ADD_VECTOR, 32'd5, '1, '1, 2'd3);
            queue_request(OP_MUL_SCALAR, 32'h8000_0000, '0, '0, WIDTH_8);
            queue_request(OP_ADD_SCALAR, 32'h7FFF_FFFF, '0, '0, WIDTH_8);
            queue_request(OP_SUM_LANES, 32'h7FFF_FFFF, '1, '1, 2'd3);
            queue_request(OP_ADD_VECTOR, 32'h8000_0000, 64'h8001_7F80_0102_FE7F,
                          64'h00FF_8000_7FFF_0180, WIDTH_8);
            queue_request(OP_SUM_LANES, 32'd0, '0, '0, WIDTH_8);
         end else if (phase == 1) begin
            // Fourth width code: it acts as 32-bit lanes and accepts a tag
            // of either two or three, but not sixteen bits.
            queue_request(OP_ADD_VECTOR, 32'd0, 64'h7FFF_FFFF_8000_0000,
                          64'hFFFF_FFFF_0000_0001, WIDTH_32);
            queue_request(OP_ADD_VECTOR, 32'd0, 64'h0000_0001_FFFF_FFFF,
                          64'h8000_0000_7FFF_FFFF, 2'd3);
            queue_request(OP_ADD_VECTOR, 32'd0, '1, '1, WIDTH_16);
            queue_request(OP_SUM_LANES, 32'd0, '0, '0, 2'd3);
            queue_request(OP_MUL_SCALAR, 32'h7FFF_FFFF, '0, '0, WIDTH_8);
         end
         repeat (RANDOM_PER_PHASE) queue_random_request(phase_width[phase]);
      end
      wait_until_drained();
      if (error_count == 0) begin
         $display("[packed_simd_vector_alu] OK");
      end else begin
         $display("[packed_simd_vector_alu] ERROR");
      end
      $finish;
   end

endmodule

### files.f
rtl/pvalu_pkg.sv
rtl/pvalu_lane.sv
rtl/pvalu_merge.sv
rtl/packed_simd_vector_alu.sv
tb/tb.sv
